[rtl/core/stdisp_pkg.sv]
// stdisp_pkg: shared types and constants of the stream tuple dispatcher.
// Used by stdisp_cfg_regs, stdisp_mod_unit and stream_tuple_dispatcher.
`default_nettype none

package stdisp_pkg;

  // Field widths
  localparam int KEY_W    = 32;
  localparam int COPY_W   = 16;
  localparam int SEQ_W    = 32;
  localparam int GIDX_W   = 2;
  localparam int RIDX_W   = 4;
  localparam int CNT_W    = 5;
  localparam int NGRP_W   = 3;
  localparam int HW_GROUPS = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLICA0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLICA1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPLICA2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLICA3 = 3'd5;

  // Grouping modes
  localparam logic MODE_SHUFFLE = 1'b0;
  localparam logic MODE_FIELD   = 1'b1;

  // Remainder unit: bits retired per iteration and iteration count
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = KEY_W / MOD_DIGIT_W;
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

  typedef logic [CNT_W-1:0] cnt_t;

  // Effective (saturated) configuration seen by the sequencer
  typedef struct packed {
    logic                       mode;
    logic [NGRP_W-1:0]          n_groups;
    cnt_t [HW_GROUPS-1:0]       cnt;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/stdisp_cfg_regs.sv]
// stdisp_cfg_regs: configuration registers with range saturation.
// Depends on stdisp_pkg.
`default_nettype none

module stdisp_cfg_regs #(
  parameter int MAX_GROUPS   = 4,
  parameter int MAX_REPLICAS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [stdisp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stdisp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output stdisp_pkg::cfg_t                         cfg_o
);

  localparam int GRP_LIM_I = (MAX_GROUPS < stdisp_pkg::HW_GROUPS) ?
                             MAX_GROUPS : stdisp_pkg::HW_GROUPS;
  localparam logic [stdisp_pkg::NGRP_W-1:0] GRP_LIM = stdisp_pkg::NGRP_W'(GRP_LIM_I);
  localparam int REP_CAP_I = (MAX_REPLICAS > 31) ? 31 : MAX_REPLICAS;
  localparam logic [stdisp_pkg::CNT_W-1:0] REP_CAP = stdisp_pkg::CNT_W'(REP_CAP_I);

  logic                              mode_r;
  logic [stdisp_pkg::NGRP_W-1:0]     active_r;
  stdisp_pkg::cnt_t [stdisp_pkg::HW_GROUPS-1:0] rep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= stdisp_pkg::MODE_SHUFFLE;
      active_r <= stdisp_pkg::NGRP_W'(1);
      for (int i = 0; i < stdisp_pkg::HW_GROUPS; i++) begin
        rep_r[i] <= stdisp_pkg::CNT_W'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        stdisp_pkg::REG_MODE:     mode_r   <= cfg_data[0];
        stdisp_pkg::REG_ACTIVE:   active_r <= cfg_data[stdisp_pkg::NGRP_W-1:0];
        stdisp_pkg::REG_REPLICA0: rep_r[0] <= cfg_data;
        stdisp_pkg::REG_REPLICA1: rep_r[1] <= cfg_data;
        stdisp_pkg::REG_REPLICA2: rep_r[2] <= cfg_data;
        stdisp_pkg::REG_REPLICA3: rep_r[3] <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_comb begin
    cfg_o.mode = mode_r;
    if (active_r == '0) begin
      cfg_o.n_groups = stdisp_pkg::NGRP_W'(1);
    end else if (active_r > GRP_LIM) begin
      cfg_o.n_groups = GRP_LIM;
    end else begin
      cfg_o.n_groups = active_r;
    end
    for (int i = 0; i < stdisp_pkg::HW_GROUPS; i++) begin
      if (rep_r[i] == '0) begin
        cfg_o.cnt[i] = stdisp_pkg::CNT_W'(1);
      end else if (rep_r[i] > REP_CAP) begin
        cfg_o.cnt[i] = REP_CAP;
      end else begin
        cfg_o.cnt[i] = rep_r[i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/stdisp_mod_unit.sv]
// stdisp_mod_unit: iterative remainder of a 32-bit key by a 5-bit count,
// four quotient bits per cycle. Depends on stdisp_pkg.
`default_nettype none

module stdisp_mod_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [stdisp_pkg::KEY_W-1:0]      dividend,
  input  wire stdisp_pkg::cnt_t                  divisor,
  output logic                                   busy,
  output stdisp_pkg::cnt_t                       remainder
);

  logic                                  busy_r;
  logic [stdisp_pkg::MOD_CNT_W-1:0]      step_r;
  logic [stdisp_pkg::KEY_W-1:0]          sh_r;
  stdisp_pkg::cnt_t                      div_r;
  stdisp_pkg::cnt_t                      rem_r;
  stdisp_pkg::cnt_t                      rem_nxt;

  // Restoring remainder over the top digit of the shifter
  always_comb begin
    logic [stdisp_pkg::CNT_W:0] t;
    rem_nxt = rem_r;
    for (int b = 0; b < stdisp_pkg::MOD_DIGIT_W; b++) begin
      t = {rem_nxt, sh_r[stdisp_pkg::KEY_W-1-b]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      rem_nxt = t[stdisp_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == stdisp_pkg::MOD_CNT_W'(stdisp_pkg::MOD_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_r << stdisp_pkg::MOD_DIGIT_W;
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[rtl/core/stream_tuple_dispatcher.sv]
// stream_tuple_dispatcher: top level with sequencer, round-robin pointers,
// sequence counter and output register.
// Depends on stdisp_pkg, stdisp_cfg_regs and stdisp_mod_unit.
//
// - Input channel (in_valid / in_stall): one tuple per transfer, carrying
//   in_key_hash and in_copy_number. in_stall is high while a tuple is being
//   fanned out.
// - Output channel (out_valid / out_stall): one routed copy per active
//   group, in ascending group order; out_last_copy marks the final copy.
// - Config port (cfg_we / cfg_index / cfg_data): write only while idle.
// - Per active group: shuffle mode loads the copy straight from the group
//   state; field mode starts the shared remainder unit, runs one pass of it
//   per 4 key bits and then loads the copy. in_stall stays high until the
//   last copy of the tuple is loaded.
// - The output register decouples the sides: the next tuple is accepted as
//   soon as the last copy is loaded, even if that copy still waits.
// - A stalled receiver freezes the sequencer at its next load; no loss.
// - Reset (rst_n low, synchronous) clears pointers, sequence counter,
//   output valid and configuration to defaults. No clearing pass.
`default_nettype none

module stream_tuple_dispatcher #(
  parameter int MAX_GROUPS   = 4,
  parameter int MAX_REPLICAS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [stdisp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [stdisp_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [stdisp_pkg::KEY_W-1:0]       in_key_hash,
  input  wire logic [stdisp_pkg::COPY_W-1:0]      in_copy_number,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [stdisp_pkg::GIDX_W-1:0]           out_group_index,
  output logic [stdisp_pkg::RIDX_W-1:0]           out_replica_index,
  output logic [stdisp_pkg::SEQ_W-1:0]            out_sequence_number,
  output logic [stdisp_pkg::COPY_W-1:0]           out_copy_out,
  output logic                                    out_last_copy
);

  // Only groups below MAX_GROUPS (capped at the hardware limit) ever get a pointer
  localparam int RR_DEPTH = (MAX_GROUPS < stdisp_pkg::HW_GROUPS) ?
                            MAX_GROUPS : stdisp_pkg::HW_GROUPS;
  localparam int RR_IW    = (RR_DEPTH > 1) ? $clog2(RR_DEPTH) : 1;

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_GROUP = 2'd1;
  localparam logic [1:0] ST_MOD   = 2'd2;

  stdisp_pkg::cfg_t cfg;

  logic [1:0]                           state_r, state_nxt;
  logic [stdisp_pkg::GIDX_W-1:0]        grp_r, grp_nxt;
  logic [stdisp_pkg::KEY_W-1:0]         key_r;
  logic [stdisp_pkg::COPY_W-1:0]        copy_r;
  logic [RR_DEPTH-1:0][stdisp_pkg::RIDX_W-1:0] rr_r;
  logic [stdisp_pkg::SEQ_W-1:0]         seq_r;

  logic                                 out_valid_r;
  logic [stdisp_pkg::GIDX_W-1:0]        out_grp_r;
  logic [stdisp_pkg::RIDX_W-1:0]        out_rep_r;
  logic [stdisp_pkg::SEQ_W-1:0]         out_seq_r;
  logic [stdisp_pkg::COPY_W-1:0]        out_copy_r;
  logic                                 out_last_r;

  logic                                 in_xfer;
  logic                                 out_free;
  logic                                 out_load;
  logic                                 is_last;
  logic                                 mod_start;
  logic                                 mod_busy;
  stdisp_pkg::cnt_t                     mod_rem;
  stdisp_pkg::cnt_t                     grp_cnt;
  logic [stdisp_pkg::RIDX_W-1:0]        rr_cur;
  logic [stdisp_pkg::RIDX_W-1:0]        rr_sel;
  logic [stdisp_pkg::RIDX_W-1:0]        rr_adv;
  logic [stdisp_pkg::CNT_W-1:0]         rr_inc;
  stdisp_pkg::cnt_t                     sel;

  stdisp_cfg_regs #(
    .MAX_GROUPS   (MAX_GROUPS),
    .MAX_REPLICAS (MAX_REPLICAS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  stdisp_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (key_r),
    .divisor   (grp_cnt),
    .busy      (mod_busy),
    .remainder (mod_rem)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign grp_cnt  = cfg.cnt[grp_r];
  assign is_last  = ({1'b0, grp_r} + stdisp_pkg::NGRP_W'(1)) == cfg.n_groups;

  // Round-robin select: a stale pointer (count lowered) restarts at zero
  assign rr_cur = rr_r[RR_IW'(grp_r)];
  assign rr_sel = ({1'b0, rr_cur} < grp_cnt) ? rr_cur : '0;
  assign rr_inc = {1'b0, rr_sel} + stdisp_pkg::CNT_W'(1);
  assign rr_adv = (rr_inc >= grp_cnt) ? '0 : rr_inc[stdisp_pkg::RIDX_W-1:0];

  assign sel = (cfg.mode == stdisp_pkg::MODE_SHUFFLE) ? {1'b0, rr_sel} : mod_rem;

  assign mod_start = (state_r == ST_GROUP) && (cfg.mode == stdisp_pkg::MODE_FIELD);
  assign out_load  = out_free &&
                     (((state_r == ST_GROUP) && (cfg.mode == stdisp_pkg::MODE_SHUFFLE)) ||
                      ((state_r == ST_MOD) && !mod_busy));

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_GROUP;
          grp_nxt   = '0;
        end
      end
      ST_GROUP: begin
        if (mod_start) begin
          state_nxt = ST_MOD;
        end else if (out_load) begin
          state_nxt = is_last ? ST_IDLE : ST_GROUP;
          grp_nxt   = grp_r + 1'b1;
        end
      end
      ST_MOD: begin
        if (out_load) begin
          state_nxt = is_last ? ST_IDLE : ST_GROUP;
          grp_nxt   = grp_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grp_r       <= '0;
      rr_r        <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        seq_r       <= seq_r + 1'b1;
        if (cfg.mode == stdisp_pkg::MODE_SHUFFLE) begin
          rr_r[RR_IW'(grp_r)] <= rr_adv;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_r  <= in_key_hash;
      copy_r <= in_copy_number;
    end
    if (out_load) begin
      out_grp_r  <= grp_r;
      out_rep_r  <= sel[stdisp_pkg::RIDX_W-1:0];
      out_seq_r  <= seq_r;
      out_copy_r <= copy_r;
      out_last_r <= is_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_group_index     = out_grp_r;
  assign out_replica_index   = out_rep_r;
  assign out_sequence_number = out_seq_r;
  assign out_copy_out        = out_copy_r;
  assign out_last_copy       = out_last_r;

  // Chosen replica is always inside the group's range
  a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (sel < grp_cnt))
    else $error("replica select out of range");

  // Remainder unit only runs while the sequencer waits on it
  a_mod_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mod_busy |-> (state_r == ST_MOD))
    else $error("remainder unit busy outside MOD state");

  // Field mode leaves the round-robin pointers alone
  a_rr_field: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg.mode == stdisp_pkg::MODE_FIELD) |=> $stable(rr_r))
    else $error("pointer moved in field mode");

  // Each routed copy consumes exactly one sequence number
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (seq_r == $past(seq_r) + 1'b1))
    else $error("sequence counter skipped");

  // The last copy ends the tuple
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && is_last) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after last copy");

endmodule

`default_nettype wire
